[hdl/bpeq_pkg.sv]
// Shared types and constants for the bit-packed column equality scan.
// No dependencies; every other file in hdl/ imports this package.
package bpeq_pkg;

    localparam int LANES      = 32;
    localparam int LANE_BITS  = 5;
    localparam int INDEX_BITS = 10;
    localparam int WORD_BITS  = 32;
    localparam int WIDTH_BITS = 6;
    localparam int HIT_BITS   = 6;
    localparam int BLOCK_BITS = 11;
    localparam int TOTAL_BITS = 48;

    localparam logic [WIDTH_BITS-1:0] MAX_WIDTH = 6'd32;
    localparam logic [BLOCK_BITS-1:0] BLOCK_MAX = 11'd2047;
    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};

    localparam logic REG_VALUE_WIDTH = 1'b0;
    localparam logic REG_MATCH_VALUE = 1'b1;

    typedef struct packed {
        logic last;
        logic active;
        logic block_end;
    } tag_t;

    function automatic logic [WORD_BITS-1:0] width_mask(input logic [WIDTH_BITS-1:0] w);
        logic [WORD_BITS-1:0] m;
        if (w >= MAX_WIDTH)
        begin
            m = {WORD_BITS{1'b1}};
        end
        else
        begin
            m = (WORD_BITS'(1) << w[4:0]) - WORD_BITS'(1);
        end
        return m;
    endfunction

endpackage

[hdl/bitpacked_equality_count_scan.sv]
// Bit-packed column equality scan: counts packed values equal to a target.
// Depends on bpeq_pkg, bpeq_carry_ram, bpeq_match and bpeq_count.
//
// Takes one 32-bit word per cycle. Each word reads its lane's previous row
// from a 32-entry carry memory and writes itself back in the same cycle, so
// back-to-back words never wait. The 32 field comparators of one word run in
// parallel; results go via s1, s2 and s3 into match_count. in_ready falls
// only while a result is held and the next column's last word has reached
// the accumulator. The user must write configuration while idle; unenforced.
module bitpacked_equality_count_scan
    import bpeq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic                  cfg_index,
    input  logic [WORD_BITS-1:0]  cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [WORD_BITS-1:0]  data_word,
    input  logic                  last_word,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [TOTAL_BITS-1:0] match_count
);

    logic [WIDTH_BITS-1:0] value_width_reg;
    logic [WORD_BITS-1:0]  match_value_reg;
    logic [WIDTH_BITS-1:0] width;
    logic [WORD_BITS-1:0]  mask;
    logic [WORD_BITS-1:0]  target;
    logic [INDEX_BITS-1:0] word_index_reg;
    logic [INDEX_BITS-1:0] word_index_next;
    logic [INDEX_BITS:0]   index_plus;
    logic                  active;
    logic                  block_end;
    logic                  accept;
    logic                  advance;
    logic                  s1_valid_reg;
    tag_t                  s1_tag_reg;
    logic [LANE_BITS-1:0]  s1_row_reg;
    logic [WORD_BITS-1:0]  s1_word_reg;
    logic [WORD_BITS-1:0]  carry;
    logic                  s2_valid;
    tag_t                  s2_tag;
    logic [LANES-1:0]      s2_hits;

    assign width  = (value_width_reg > MAX_WIDTH) ? MAX_WIDTH : value_width_reg;
    assign mask   = width_mask(width);
    assign target = match_value_reg & mask;

    assign in_ready = advance;
    assign accept   = in_valid && in_ready;
    assign active   = (width != '0);

    always_comb
    begin
        index_plus = {1'b0, word_index_reg} + (INDEX_BITS+1)'(1);
        block_end  = active && (index_plus >= {width, 5'd0});
        if (last_word || block_end)
        begin
            word_index_next = '0;
        end
        else if (active)
        begin
            word_index_next = index_plus[INDEX_BITS-1:0];
        end
        else
        begin
            word_index_next = word_index_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_width_reg <= MAX_WIDTH;
            match_value_reg <= '0;
            word_index_reg  <= '0;
            s1_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_VALUE_WIDTH: value_width_reg <= cfg_data[WIDTH_BITS-1:0];
                    REG_MATCH_VALUE: match_value_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (accept)
            begin
                word_index_reg <= word_index_next;
            end
            if (advance)
            begin
                s1_valid_reg <= accept;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_tag_reg  <= '{last: last_word, active: active, block_end: block_end};
            s1_row_reg  <= word_index_reg[INDEX_BITS-1:LANE_BITS];
            s1_word_reg <= data_word;
        end
    end

    bpeq_carry_ram u_carry_ram (
        .clk     (clk),
        .wr_en   (accept && active),
        .wr_addr (word_index_reg[LANE_BITS-1:0]),
        .wr_data (data_word),
        .rd_en   (accept),
        .rd_addr (word_index_reg[LANE_BITS-1:0]),
        .rd_data (carry)
    );

    bpeq_match u_match (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .s1_valid (s1_valid_reg),
        .s1_tag   (s1_tag_reg),
        .s1_row   (s1_row_reg),
        .s1_word  (s1_word_reg),
        .carry    (carry),
        .width    (width),
        .mask     (mask),
        .target   (target),
        .s2_valid (s2_valid),
        .s2_tag   (s2_tag),
        .s2_hits  (s2_hits)
    );

    bpeq_count u_count (
        .clk         (clk),
        .rst_n       (rst_n),
        .s2_valid    (s2_valid),
        .s2_tag      (s2_tag),
        .s2_hits     (s2_hits),
        .advance     (advance),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .match_count (match_count)
    );

    a_last_clears_index: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && last_word) |=> (word_index_reg == '0)
    ) else $error("word index not cleared after last word");

    a_ready_only_on_held_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready)
    ) else $error("input stalled without a held result");

    a_accept_fills_stage: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> s1_valid_reg
    ) else $error("accepted request lost at first stage");

    a_index_in_block: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && block_end) |=> (word_index_reg == '0)
    ) else $error("word index not cleared at block end");

endmodule

[hdl/bpeq_carry_ram.sv]
// Per-lane carry memory: one write port, one registered read port.
// Depends on bpeq_pkg. A read at the write address returns the old word.
module bpeq_carry_ram
    import bpeq_pkg::*;
(
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [LANE_BITS-1:0] wr_addr,
    input  logic [WORD_BITS-1:0] wr_data,
    input  logic                 rd_en,
    input  logic [LANE_BITS-1:0] rd_addr,
    output logic [WORD_BITS-1:0] rd_data
);

    logic [WORD_BITS-1:0] mem [LANES];
    logic [WORD_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[hdl/bpeq_match.sv]
// Field rebuild and compare stage: one comparator per field slot.
// Depends on bpeq_pkg; fed by the carry memory and the request stage.
module bpeq_match
    import bpeq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  advance,
    input  logic                  s1_valid,
    input  tag_t                  s1_tag,
    input  logic [LANE_BITS-1:0]  s1_row,
    input  logic [WORD_BITS-1:0]  s1_word,
    input  logic [WORD_BITS-1:0]  carry,
    input  logic [WIDTH_BITS-1:0] width,
    input  logic [WORD_BITS-1:0]  mask,
    input  logic [WORD_BITS-1:0]  target,
    output logic                  s2_valid,
    output tag_t                  s2_tag,
    output logic [LANES-1:0]      s2_hits
);

    logic [LANES-1:0]        hit_next;
    logic                    s2_valid_reg;
    tag_t                    s2_tag_reg;
    logic [LANES-1:0]        s2_hits_reg;
    logic [2*WORD_BITS-1:0]  joined;

    assign joined = {s1_word, carry};

    for (genvar p = 0; p < LANES; p++)
    begin : g_slot
        logic [INDEX_BITS-1:0]  start;
        logic [INDEX_BITS-1:0]  stop;
        logic                   in_row;
        logic                   straddle;
        logic [WIDTH_BITS-1:0]  amt;
        logic [2*WORD_BITS-1:0] shifted;
        logic [WORD_BITS-1:0]   field;

        assign start    = INDEX_BITS'(p) * {4'd0, width};
        assign stop     = start + {4'd0, width} - INDEX_BITS'(1);
        assign in_row   = (stop[9:5] == s1_row);
        assign straddle = (start[9:5] != s1_row);
        assign amt      = {~straddle, start[4:0]};
        assign shifted  = joined >> amt;
        assign field    = shifted[WORD_BITS-1:0] & mask;
        assign hit_next[p] = s1_tag.active && in_row && (field == target);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s2_valid_reg <= s1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_tag_reg  <= s1_tag;
            s2_hits_reg <= hit_next;
        end
    end

    assign s2_valid = s2_valid_reg;
    assign s2_tag   = s2_tag_reg;
    assign s2_hits  = s2_hits_reg;

endmodule

[hdl/bpeq_count.sv]
// Hit count, block and total accumulation, and the result register.
// Depends on bpeq_pkg; fed by bpeq_match.
module bpeq_count
    import bpeq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s2_valid,
    input  tag_t                  s2_tag,
    input  logic [LANES-1:0]      s2_hits,
    output logic                  advance,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [TOTAL_BITS-1:0] match_count
);

    logic                  s3_valid_reg;
    tag_t                  s3_tag_reg;
    logic [HIT_BITS-1:0]   s3_hits_reg;
    logic [HIT_BITS-1:0]   hits_next;
    logic [BLOCK_BITS-1:0] block_reg;
    logic [BLOCK_BITS-1:0] block_next;
    logic [BLOCK_BITS:0]   block_sum;
    logic [TOTAL_BITS-1:0] total_reg;
    logic [TOTAL_BITS-1:0] total_next;
    logic [TOTAL_BITS:0]   total_sum;
    logic                  out_valid_reg;
    logic [TOTAL_BITS-1:0] count_reg;
    logic                  retire;

    always_comb
    begin
        hits_next = '0;
        for (int i = 0; i < LANES; i++)
        begin
            hits_next = hits_next + HIT_BITS'(s2_hits[i]);
        end
    end

    assign advance = !(s3_valid_reg && s3_tag_reg.last && out_valid_reg && !out_ready);
    assign retire  = advance && s3_valid_reg;

    always_comb
    begin
        block_sum  = {1'b0, block_reg} + (BLOCK_BITS+1)'(s3_hits_reg);
        block_next = block_sum[BLOCK_BITS] ? BLOCK_MAX : block_sum[BLOCK_BITS-1:0];
        total_sum  = {1'b0, total_reg} + (TOTAL_BITS+1)'(block_next);
        total_next = total_sum[TOTAL_BITS] ? TOTAL_MAX : total_sum[TOTAL_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg  <= 1'b0;
            block_reg     <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                s3_valid_reg <= s2_valid;
            end
            if (retire && s3_tag_reg.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (retire)
            begin
                if (s3_tag_reg.last)
                begin
                    block_reg <= '0;
                    total_reg <= '0;
                end
                else if (s3_tag_reg.active)
                begin
                    if (s3_tag_reg.block_end)
                    begin
                        block_reg <= '0;
                        total_reg <= total_next;
                    end
                    else
                    begin
                        block_reg <= block_next;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s3_tag_reg  <= s2_tag;
            s3_hits_reg <= hits_next;
        end
        if (retire && s3_tag_reg.last)
        begin
            if (!s3_tag_reg.active)
            begin
                count_reg <= '0;
            end
            else if (s3_tag_reg.block_end)
            begin
                count_reg <= total_next;
            end
            else
            begin
                count_reg <= total_reg;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign match_count = count_reg;

endmodule
